// File: hw/rtl/trajectory_window_nearest_point_unit_assert.svh
// Assertion macros for the trajectory window nearest point unit.
// Included by the top level; expects signals clk and rst_n in scope.
`ifndef TRAJECTORY_WINDOW_NEAREST_POINT_UNIT_ASSERT_SVH
`define TRAJECTORY_WINDOW_NEAREST_POINT_UNIT_ASSERT_SVH

// same-cycle implication
`define TWNP_ASSERT_IMP(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// next-cycle implication
`define TWNP_ASSERT_NXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/twnp_pkg.sv
// Shared types and constants for the trajectory window nearest point unit.
// No dependencies.
package twnp_pkg;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_START = 2'd1,
        ACT_POSE  = 2'd2,
        ACT_TICK  = 2'd3
    } action_t;

    typedef struct packed {
        logic [31:0] lateral_d;
        logic [31:0] arc_s;
        logic [31:0] curvature;
        logic [31:0] speed;
        logic [31:0] heading;
        logic [31:0] y;
        logic [31:0] x;
    } point_t;

    // padding point: all zero, speed 0.6 in Q15.16
    localparam logic [31:0] ZERO_SPEED = 32'd39322;
    localparam point_t PAD_POINT = '{lateral_d: 32'd0, arc_s: 32'd0, curvature: 32'd0,
                                     speed: ZERO_SPEED, heading: 32'd0, y: 32'd0, x: 32'd0};

    localparam logic [8:0] WS_RESET  = 9'd200;
    localparam logic [8:0] START_PAD = 9'd10;

    localparam int SQRT_IN_W  = 64;
    localparam int SQRT_OUT_W = 32;

endpackage

// File: hw/rtl/twnp_isqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle.
// Depends on twnp_pkg for widths.
module twnp_isqrt (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [twnp_pkg::SQRT_IN_W-1:0]   radicand,
    output logic                             busy,
    output logic [twnp_pkg::SQRT_OUT_W-1:0]  root
);
    import twnp_pkg::*;

    localparam int RMW = SQRT_OUT_W + 2;

    logic [SQRT_IN_W-1:0]  val_reg, val_next;
    logic [RMW-1:0]        rem_reg, rem_next;
    logic [SQRT_OUT_W-1:0] root_reg, root_next;
    logic [5:0]            cnt_reg, cnt_next;
    logic [RMW+1:0]        shifted;
    logic [RMW+1:0]        trial;

    // one result bit per step
    always_comb
    begin
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        shifted   = {rem_reg, val_reg[SQRT_IN_W-1 -: 2]};
        trial     = (RMW+2)'({root_reg, 2'b01});
        if (start)
        begin
            val_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = 6'(SQRT_OUT_W);
        end
        else if (cnt_reg != 6'd0)
        begin
            val_next = {val_reg[SQRT_IN_W-3:0], 2'b00};
            cnt_next = cnt_reg - 6'd1;
            if (shifted >= trial)
            begin
                rem_next  = RMW'(shifted - trial);
                root_next = {root_reg[SQRT_OUT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = RMW'(shifted);
                root_next = {root_reg[SQRT_OUT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = (cnt_reg != 6'd0);
    assign root = root_reg;

endmodule

// File: hw/rtl/trajectory_window_nearest_point_unit.sv
// Top level: point store, window ring, tick sequencer and nearest search.
// Depends on twnp_pkg, twnp_isqrt and the assertion macro header.

// Command-style block. Load and pose items finish in the cycle they are taken
// (busy stays low). A start item fills the window one ring entry per cycle:
// window_size/2+10 pad entries, then up to window_size/2-10 stored points. A
// tick does the end check, appends ADVANCE_STEP points, reads the middle point,
// runs the nearest scan (one window entry per cycle through a ring read, a
// store read, a difference, a squaring and a compare stage), then runs the
// square root unit and the final point read. Results appear as one-cycle
// strobes on result_valid; the receiver cannot hold them off, so it must
// take every strobed result. Point stores and the ring need no clearing.
module trajectory_window_nearest_point_unit #(
    parameter int TRAJ_DEPTH   = 4096,
    parameter int WINDOW_DEPTH = 512,
    parameter int ADVANCE_STEP = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        window_size_we,
    input  logic [8:0]  window_size,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [31:0] point_x,
    input  logic [31:0] point_y,
    input  logic [31:0] heading,
    input  logic [31:0] speed,
    input  logic [31:0] curvature,
    input  logic [31:0] arc_s,
    input  logic [31:0] lateral_d,
    input  logic [31:0] pose_x,
    input  logic [31:0] pose_y,
    output logic        result_valid,
    output logic        kind,
    output logic [31:0] out_x,
    output logic [31:0] out_y,
    output logic [31:0] out_heading,
    output logic [31:0] out_speed,
    output logic [31:0] out_curvature,
    output logic [31:0] out_arc_s,
    output logic [31:0] out_lateral_d,
    output logic [8:0]  nearest_index,
    output logic [31:0] nearest_distance,
    output logic        last
);
    import twnp_pkg::*;

`include "trajectory_window_nearest_point_unit_assert.svh"

    localparam int CW = $clog2(TRAJ_DEPTH + 1);
    localparam int AW = $clog2(TRAJ_DEPTH);
    localparam int RW = $clog2(WINDOW_DEPTH);
    localparam int LW = $clog2(WINDOW_DEPTH + 1);
    localparam int SW = $clog2(ADVANCE_STEP + 1);
    localparam logic [CW-1:0] ZERO_ENTRY = CW'(TRAJ_DEPTH);

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_FILL = 13'b0000000000010,
        S_CHK0 = 13'b0000000000100,
        S_CHK1 = 13'b0000000001000,
        S_CHK2 = 13'b0000000010000,
        S_PUSH = 13'b0000000100000,
        S_MID0 = 13'b0000001000000,
        S_MID1 = 13'b0000010000000,
        S_MID2 = 13'b0000100000000,
        S_SCAN = 13'b0001000000000,
        S_FIN0 = 13'b0010000000000,
        S_FIN1 = 13'b0100000000000,
        S_FIN2 = 13'b1000000000000
    } state_t;

    function automatic logic [RW-1:0] ring_addr(input logic [RW-1:0] h,
                                                input logic [LW-1:0] p);
        logic [LW:0] s;
        s = (LW+1)'(h) + (LW+1)'(p);
        if (s >= (LW+1)'(WINDOW_DEPTH))
        begin
            s = s - (LW+1)'(WINDOW_DEPTH);
        end
        return s[RW-1:0];
    endfunction

    // memories
    point_t          store_mem [TRAJ_DEPTH];
    logic [CW-1:0]   ring_mem  [WINDOW_DEPTH];
    point_t          store_q;
    logic            zero_q;
    logic [CW-1:0]   ring_q;
    logic [RW-1:0]   ring_raddr;
    logic            ring_we;
    logic [RW-1:0]   ring_waddr;
    logic [CW-1:0]   ring_wdata;
    logic            store_we;

    // control state
    state_t          state_reg, state_next;
    logic [8:0]      ws_reg, ws_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   next_pt_reg, next_pt_next;
    logic [RW-1:0]   head_reg, head_next;
    logic [LW-1:0]   len_reg, len_next;
    logic            started_reg, started_next;
    logic            pose_seen_reg, pose_seen_next;
    logic [31:0]     veh_x_reg, veh_x_next;
    logic [31:0]     veh_y_reg, veh_y_next;
    logic [31:0]     last_x_reg, last_x_next;
    logic [31:0]     last_y_reg, last_y_next;
    logic [9:0]      fill_i_reg, fill_i_next;
    logic [9:0]      fill_total_reg, fill_total_next;
    logic [8:0]      fill_nz_reg, fill_nz_next;
    logic [SW-1:0]   step_reg, step_next;
    logic [LW-1:0]   scan_i_reg, scan_i_next;

    // scan pipeline
    logic            s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    logic [LW-1:0]   s1_i_reg, s2_i_reg, s3_i_reg, s4_i_reg;
    logic [31:0]     mx_reg, my_reg;
    logic [63:0]     sqx_reg, sqy_reg;
    logic [64:0]     best_reg, best_next;
    logic [LW-1:0]   best_i_reg, best_i_next;
    logic            have_reg, have_next;
    logic            scan_issue;

    // outputs
    logic            rv_reg, rv_next;
    logic            kind_reg, kind_next;
    point_t          opt_reg, opt_next;
    logic [8:0]      oidx_reg, oidx_next;
    logic [31:0]     odist_reg, odist_next;
    logic            olast_reg, olast_next;

    logic            sq_start;
    logic            sq_busy;
    logic [31:0]     sq_root;

    logic [7:0]      mid8;
    logic [LW-1:0]   mid_pos;
    logic            len_gt_mid;
    point_t          pt_eff;
    logic [7:0]      half;
    logic [7:0]      n_pts;
    logic [LW-1:0]   adv;
    logic [CW-1:0]   lastp;
    logic [64:0]     sum;
    logic [32:0]     dx, dy;
    logic [31:0]     near_idx32;

    twnp_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (best_reg[63:0]),
        .busy     (sq_busy),
        .root     (sq_root)
    );

    // memory ports
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[count_reg[AW-1:0]] <= '{lateral_d: lateral_d, arc_s: arc_s,
                                              curvature: curvature, speed: speed,
                                              heading: heading, y: point_y, x: point_x};
        end
        store_q <= store_mem[ring_q[AW-1:0]];
        zero_q  <= (ring_q == ZERO_ENTRY);
        if (ring_we)
        begin
            ring_mem[ring_waddr] <= ring_wdata;
        end
        ring_q <= ring_mem[ring_raddr];
    end

    // derived values
    always_comb
    begin
        mid8       = ws_reg[8:1];
        mid_pos    = (32'(mid8) >= WINDOW_DEPTH) ? '0 : LW'(mid8);
        len_gt_mid = (32'(len_reg) > 32'(mid8));
        pt_eff     = zero_q ? PAD_POINT : store_q;
        half       = ws_reg[8:1];
        n_pts      = (half >= 8'(START_PAD)) ? (half - 8'(START_PAD)) : 8'd0;
        if (32'(n_pts) > 32'(count_reg))
        begin
            n_pts = 8'(count_reg);
        end
        adv        = (32'(len_reg) < ADVANCE_STEP) ? len_reg : LW'(ADVANCE_STEP);
        lastp      = count_reg - CW'(1);
        scan_issue = (state_reg == S_SCAN) && (scan_i_reg < len_reg);
        dx         = {pt_eff.x[31], pt_eff.x} - {veh_x_reg[31], veh_x_reg};
        dy         = {pt_eff.y[31], pt_eff.y} - {veh_y_reg[31], veh_y_reg};
        sum        = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        near_idx32 = 32'(best_i_reg);
    end

    // ring read address
    always_comb
    begin
        case (state_reg)
            S_CHK0, S_CHK1, S_CHK2, S_MID0, S_MID1, S_MID2:
                ring_raddr = ring_addr(head_reg, mid_pos);
            S_SCAN:
                ring_raddr = ring_addr(head_reg, scan_i_reg);
            S_FIN0, S_FIN1, S_FIN2:
                ring_raddr = ring_addr(head_reg, best_i_reg);
            default:
                ring_raddr = '0;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        ws_next         = window_size_we ? window_size : ws_reg;
        count_next      = count_reg;
        next_pt_next    = next_pt_reg;
        head_next       = head_reg;
        len_next        = len_reg;
        started_next    = started_reg;
        pose_seen_next  = pose_seen_reg;
        veh_x_next      = veh_x_reg;
        veh_y_next      = veh_y_reg;
        last_x_next     = last_x_reg;
        last_y_next     = last_y_reg;
        fill_i_next     = fill_i_reg;
        fill_total_next = fill_total_reg;
        fill_nz_next    = fill_nz_reg;
        step_next       = step_reg;
        scan_i_next     = scan_i_reg;
        best_next       = best_reg;
        best_i_next     = best_i_reg;
        have_next       = have_reg;
        rv_next         = 1'b0;
        kind_next       = kind_reg;
        opt_next        = opt_reg;
        oidx_next       = oidx_reg;
        odist_next      = odist_reg;
        olast_next      = olast_reg;
        store_we        = 1'b0;
        ring_we         = 1'b0;
        ring_waddr      = '0;
        ring_wdata      = '0;
        sq_start        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (action)
                        ACT_LOAD:
                        begin
                            if (32'(count_reg) < TRAJ_DEPTH)
                            begin
                                store_we    = 1'b1;
                                count_next  = count_reg + CW'(1);
                                last_x_next = point_x;
                                last_y_next = point_y;
                            end
                        end
                        ACT_START:
                        begin
                            head_next       = '0;
                            len_next        = '0;
                            fill_i_next     = '0;
                            fill_nz_next    = {1'b0, half} + START_PAD;
                            fill_total_next = 10'({1'b0, half} + START_PAD) + 10'(n_pts);
                            next_pt_next    = CW'(n_pts);
                            started_next    = 1'b1;
                            state_next      = S_FILL;
                        end
                        ACT_POSE:
                        begin
                            veh_x_next     = pose_x;
                            veh_y_next     = pose_y;
                            pose_seen_next = 1'b1;
                        end
                        ACT_TICK:
                        begin
                            if (count_reg != '0 && started_reg)
                            begin
                                state_next = S_CHK0;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // pad entries, then the first stored points
            S_FILL:
            begin
                if (32'(len_reg) < WINDOW_DEPTH)
                begin
                    ring_we    = 1'b1;
                    ring_waddr = ring_addr('0, len_reg);
                    ring_wdata = (fill_i_reg < 10'(fill_nz_reg)) ? ZERO_ENTRY
                                 : CW'(fill_i_reg - 10'(fill_nz_reg));
                    len_next   = len_reg + LW'(1);
                end
                fill_i_next = fill_i_reg + 10'd1;
                if (fill_i_reg == fill_total_reg - 10'd1)
                begin
                    state_next = S_IDLE;
                end
            end

            S_CHK0:
                state_next = S_CHK1;
            S_CHK1:
                state_next = S_CHK2;

            // end-of-trajectory check, then drop the oldest entries
            S_CHK2:
            begin
                if (next_pt_reg >= count_reg && len_gt_mid &&
                    pt_eff.x == last_x_reg && pt_eff.y == last_y_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    head_next  = ring_addr(head_reg, adv);
                    len_next   = len_reg - adv;
                    step_next  = '0;
                    state_next = S_PUSH;
                end
            end

            // append next points, repeating the last one at the end
            S_PUSH:
            begin
                if (32'(len_reg) < WINDOW_DEPTH)
                begin
                    ring_we    = 1'b1;
                    ring_waddr = ring_addr(head_reg, len_reg);
                    ring_wdata = (next_pt_reg < count_reg) ? next_pt_reg : lastp;
                    len_next   = len_reg + LW'(1);
                end
                if (next_pt_reg < count_reg)
                begin
                    next_pt_next = next_pt_reg + CW'(1);
                end
                step_next = step_reg + SW'(1);
                if (32'(step_reg) == ADVANCE_STEP - 1)
                begin
                    state_next = S_MID0;
                end
            end

            S_MID0:
            begin
                scan_i_next = '0;
                have_next   = 1'b0;
                if (len_gt_mid)
                begin
                    state_next = S_MID1;
                end
                else if (pose_seen_reg && len_reg != '0)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_MID1:
                state_next = S_MID2;

            // middle point transfer
            S_MID2:
            begin
                rv_next    = 1'b1;
                kind_next  = 1'b0;
                opt_next   = pt_eff;
                oidx_next  = '0;
                odist_next = '0;
                olast_next = !pose_seen_reg;
                state_next = pose_seen_reg ? S_SCAN : S_IDLE;
            end

            // stream window through the distance pipeline
            S_SCAN:
            begin
                if (scan_issue)
                begin
                    scan_i_next = scan_i_reg + LW'(1);
                end
                if (!scan_issue && !s1_v_reg && !s2_v_reg && !s3_v_reg && !s4_v_reg)
                begin
                    state_next = S_FIN0;
                end
            end

            S_FIN0:
            begin
                sq_start   = !best_reg[64];
                state_next = S_FIN1;
            end

            S_FIN1:
                state_next = S_FIN2;

            // nearest point transfer once the root is ready
            S_FIN2:
            begin
                if (!sq_busy)
                begin
                    rv_next    = 1'b1;
                    kind_next  = 1'b1;
                    opt_next   = pt_eff;
                    oidx_next  = near_idx32[8:0];
                    odist_next = best_reg[64] ? 32'hFFFF_FFFF : sq_root;
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase

        // running minimum, first of equals kept
        if (s4_v_reg && (!have_reg || sum < best_reg))
        begin
            have_next   = 1'b1;
            best_next   = sum;
            best_i_next = s4_i_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ws_reg        <= WS_RESET;
            count_reg     <= '0;
            next_pt_reg   <= '0;
            head_reg      <= '0;
            len_reg       <= '0;
            started_reg   <= 1'b0;
            pose_seen_reg <= 1'b0;
            veh_x_reg     <= '0;
            veh_y_reg     <= '0;
            have_reg      <= 1'b0;
            rv_reg        <= 1'b0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            s4_v_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ws_reg        <= ws_next;
            count_reg     <= count_next;
            next_pt_reg   <= next_pt_next;
            head_reg      <= head_next;
            len_reg       <= len_next;
            started_reg   <= started_next;
            pose_seen_reg <= pose_seen_next;
            veh_x_reg     <= veh_x_next;
            veh_y_reg     <= veh_y_next;
            have_reg      <= have_next;
            rv_reg        <= rv_next;
            s1_v_reg      <= scan_issue;
            s2_v_reg      <= s1_v_reg;
            s3_v_reg      <= s2_v_reg;
            s4_v_reg      <= s3_v_reg;
        end
    end

    // payload and datapath registers
    always_ff @(posedge clk)
    begin
        last_x_reg     <= last_x_next;
        last_y_reg     <= last_y_next;
        fill_i_reg     <= fill_i_next;
        fill_total_reg <= fill_total_next;
        fill_nz_reg    <= fill_nz_next;
        step_reg       <= step_next;
        scan_i_reg     <= scan_i_next;
        best_reg       <= best_next;
        best_i_reg     <= best_i_next;
        kind_reg       <= kind_next;
        opt_reg        <= opt_next;
        oidx_reg       <= oidx_next;
        odist_reg      <= odist_next;
        olast_reg      <= olast_next;
        s1_i_reg       <= scan_i_reg;
        s2_i_reg       <= s1_i_reg;
        s3_i_reg       <= s2_i_reg;
        s4_i_reg       <= s3_i_reg;
        mx_reg         <= dx[32] ? 32'(-dx) : dx[31:0];
        my_reg         <= dy[32] ? 32'(-dy) : dy[31:0];
        sqx_reg        <= mx_reg * mx_reg;
        sqy_reg        <= my_reg * my_reg;
    end

    assign busy             = (state_reg != S_IDLE);
    assign result_valid     = rv_reg;
    assign kind             = kind_reg;
    assign out_x            = opt_reg.x;
    assign out_y            = opt_reg.y;
    assign out_heading      = opt_reg.heading;
    assign out_speed        = opt_reg.speed;
    assign out_curvature    = opt_reg.curvature;
    assign out_arc_s        = opt_reg.arc_s;
    assign out_lateral_d    = opt_reg.lateral_d;
    assign nearest_index    = oidx_reg;
    assign nearest_distance = odist_reg;
    assign last             = olast_reg;

    `TWNP_ASSERT_IMP(a_len_bound, 1'b1, len_reg <= LW'(WINDOW_DEPTH))
    `TWNP_ASSERT_IMP(a_near_is_last, result_valid && kind, last)
    `TWNP_ASSERT_NXT(a_last_gap, result_valid && last, !result_valid)
    `TWNP_ASSERT_IMP(a_sqrt_idle_scan, state_reg == S_SCAN, !sq_busy)

endmodule
